// File: rtl/core/hpd_pkg.sv
// Shared constants and types for the horizontal predictor decoder.
package hpd_pkg;

  localparam int MaxChannels = 8;
  localparam int ChanW       = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
  localparam int ChCntW      = $clog2(MaxChannels + 1);

  localparam int SampleW = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgSampleBytes = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgChannels    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRowPixels   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRowCount    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSwapBytes   = 3'd4;

  localparam logic [1:0] SampleBytesWide = 2'd2;

  localparam logic [SampleW-1:0] MaskWide   = 16'hffff;
  localparam logic [SampleW-1:0] MaskNarrow = 16'h00ff;

  typedef struct packed {
    logic wr;
    logic pixel_done;
    logic beyond;
  } step_t;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               row_end;
    logic               image_end;
  } res_t;

endpackage

// File: rtl/core/hpd_cell.sv
// One channel cell: holds a running sum and passes the channel token to its neighbor.
module hpd_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hpd_pkg::step_t               step_i,
  input  logic                         last_i,
  input  logic                         tok_i,
  input  logic [hpd_pkg::SampleW-1:0]  wr_data_i,
  input  logic [hpd_pkg::SampleW-1:0]  rd_i,
  output logic                         tok_o,
  output logic [hpd_pkg::SampleW-1:0]  rd_o
);

  logic                        tok_q, tok_d;
  logic [hpd_pkg::SampleW-1:0] sum_q;
  logic                        sel;

  assign sel   = step_i.beyond ? last_i : tok_i;
  assign rd_o  = sel ? sum_q : rd_i;
  assign tok_o = tok_q;

  always_comb begin
    tok_d = tok_q;
    if (step_i.wr) begin
      tok_d = step_i.pixel_done ? 1'b0 : tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.wr && sel) begin
      sum_q <= wr_data_i;
    end
  end

endmodule

// File: rtl/core/hpd_ctrl.sv
// Configuration registers, raster position counters and the sample adder.
module hpd_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hpd_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [hpd_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                              accept_i,
  input  logic [hpd_pkg::SampleW-1:0]       coded_sample_i,
  input  logic [hpd_pkg::SampleW-1:0]       rd_i,
  output logic                              head_o,
  output logic [hpd_pkg::MaxChannels-1:0]   last_o,
  output hpd_pkg::step_t                    step_o,
  output hpd_pkg::res_t                     res_o
);

  logic [1:0]                  sample_bytes_q;
  logic [3:0]                  channels_q;
  logic [15:0]                 row_pixels_q;
  logic [15:0]                 row_count_q;
  logic                        swap_bytes_q;

  logic [hpd_pkg::ChanW-1:0]   channel_pos_q, channel_pos_d;
  logic [15:0]                 column_pos_q, column_pos_d;
  logic [15:0]                 row_pos_q, row_pos_d;

  logic                        wide;
  logic [hpd_pkg::SampleW-1:0] mask;
  logic [hpd_pkg::SampleW-1:0] v;
  logic [hpd_pkg::SampleW-1:0] sum;
  logic [hpd_pkg::ChCntW-1:0]  ch_eff;
  logic [hpd_pkg::ChCntW-1:0]  pos_ext;
  logic [15:0]                 rp_eff;
  logic [15:0]                 rc_eff;
  logic [16:0]                 col_next;
  logic [16:0]                 row_next;
  logic                        pixel_done;
  logic                        row_done;
  logic                        image_done;

  assign wide = (sample_bytes_q == hpd_pkg::SampleBytesWide);
  assign mask = wide ? hpd_pkg::MaskWide : hpd_pkg::MaskNarrow;

  always_comb begin
    v = coded_sample_i;
    if (wide && swap_bytes_q) begin
      v = {coded_sample_i[7:0], coded_sample_i[15:8]};
    end
    v = v & mask;
  end

  always_comb begin
    if (channels_q == 4'd0) begin
      ch_eff = hpd_pkg::ChCntW'(1);
    end else if (int'(channels_q) > hpd_pkg::MaxChannels) begin
      ch_eff = hpd_pkg::ChCntW'(hpd_pkg::MaxChannels);
    end else begin
      ch_eff = hpd_pkg::ChCntW'(channels_q);
    end
  end

  assign rp_eff   = (row_pixels_q == 16'd0) ? 16'd1 : row_pixels_q;
  assign rc_eff   = (row_count_q == 16'd0) ? 16'd1 : row_count_q;
  assign pos_ext  = hpd_pkg::ChCntW'(channel_pos_q);
  assign col_next = {1'b0, column_pos_q} + 17'd1;
  assign row_next = {1'b0, row_pos_q} + 17'd1;

  assign pixel_done = (pos_ext + hpd_pkg::ChCntW'(1)) >= ch_eff;
  assign row_done   = pixel_done && (col_next >= {1'b0, rp_eff});
  assign image_done = row_done && (row_next >= {1'b0, rc_eff});

  assign sum = (column_pos_q == 16'd0) ? v : ((rd_i + v) & mask);

  assign head_o = (channel_pos_q == '0);

  for (genvar i = 0; i < hpd_pkg::MaxChannels; i++) begin : g_last
    assign last_o[i] = (ch_eff == hpd_pkg::ChCntW'(i + 1));
  end

  assign step_o.wr         = accept_i;
  assign step_o.pixel_done = pixel_done;
  assign step_o.beyond     = pos_ext >= ch_eff;

  assign res_o.sample    = sum;
  assign res_o.row_end   = row_done;
  assign res_o.image_end = image_done;

  always_comb begin
    channel_pos_d = channel_pos_q;
    column_pos_d  = column_pos_q;
    row_pos_d     = row_pos_q;
    if (accept_i) begin
      if (pixel_done) begin
        channel_pos_d = '0;
        if (row_done) begin
          column_pos_d = 16'd0;
          row_pos_d    = image_done ? 16'd0 : row_next[15:0];
        end else begin
          column_pos_d = col_next[15:0];
        end
      end else begin
        channel_pos_d = channel_pos_q + hpd_pkg::ChanW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_bytes_q <= 2'd1;
      channels_q     <= 4'd1;
      row_pixels_q   <= 16'd1;
      row_count_q    <= 16'd1;
      swap_bytes_q   <= 1'b0;
      channel_pos_q  <= '0;
      column_pos_q   <= 16'd0;
      row_pos_q      <= 16'd0;
    end else begin
      channel_pos_q <= channel_pos_d;
      column_pos_q  <= column_pos_d;
      row_pos_q     <= row_pos_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          hpd_pkg::CfgSampleBytes: sample_bytes_q <= cfg_wdata_i[1:0];
          hpd_pkg::CfgChannels:    channels_q     <= cfg_wdata_i[3:0];
          hpd_pkg::CfgRowPixels:   row_pixels_q   <= cfg_wdata_i[15:0];
          hpd_pkg::CfgRowCount:    row_count_q    <= cfg_wdata_i[15:0];
          hpd_pkg::CfgSwapBytes:   swap_bytes_q   <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: rtl/core/hpd_skid.sv
// Output register with a skid stage on the result channel.
module hpd_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hpd_pkg::res_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hpd_pkg::res_t  out_data_o
);

  logic          out_vld_q, out_vld_d;
  logic          skid_vld_q, skid_vld_d;
  hpd_pkg::res_t out_q;
  hpd_pkg::res_t skid_q;
  logic          accept;
  logic          out_free;

  assign in_ready_o  = !skid_vld_q;
  assign accept      = in_valid_i && !skid_vld_q;
  assign out_free    = !out_vld_q || out_ready_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    if (accept) begin
      if (out_free) begin
        out_vld_d = 1'b1;
      end else begin
        skid_vld_d = 1'b1;
      end
    end else if (out_ready_i) begin
      if (skid_vld_q) begin
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && out_free) begin
      out_q <= in_data_i;
    end else if (accept) begin
      skid_q <= in_data_i;
    end else if (out_ready_i && skid_vld_q) begin
      out_q <= skid_q;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid beat held with empty output register");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |=> out_vld_q)
    else $error("stalled output beat dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |=> $stable(out_q))
    else $error("stalled output beat changed");
`endif

endmodule

// File: rtl/core/horizontal_predictor_decoder.sv
// Top level of the horizontal predictor decoder.
// Usage:
//   Input channel (in_valid_i / in_ready_o / coded_sample_i) carries one coded
//   sample per beat in row-major, channel-interleaved order. Output channel
//   (out_valid_o / out_ready_i) carries one reconstructed sample per input
//   beat, with row_end_o and image_end_o marking the last sample of a row and
//   of the image.
//   Configuration: write cfg_wdata_i to register cfg_index_i while cfg_we_i is
//   high; write only while no beat is in flight.
//   Output: each result is registered in the output register or skid stage.
//   Throughput: one sample per cycle while in_ready_o is high, set by the single
//   add with feedback from the channel cell chain into the next sample.
//   Reset: clears positions so the next beat starts a new image; the channel
//   sums are loaded by the first pixel of each row and need no clearing.
//   Stall: an output register plus a skid stage hold up to two results;
//   in_ready_o drops only while the skid stage is full.
module horizontal_predictor_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hpd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [hpd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hpd_pkg::SampleW-1:0]   coded_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hpd_pkg::SampleW-1:0]   pixel_sample_o,
  output logic                          row_end_o,
  output logic                          image_end_o
);

  logic                                 accept;
  logic                                 head;
  logic [hpd_pkg::MaxChannels-1:0]      last;
  hpd_pkg::step_t                       step;
  hpd_pkg::res_t                        res;
  hpd_pkg::res_t                        out_res;
  logic [hpd_pkg::MaxChannels:0]        tok;
  logic [hpd_pkg::SampleW-1:0]          rd [hpd_pkg::MaxChannels+1];

  assign accept = in_valid_i && in_ready_o;
  assign tok[0] = head;
  assign rd[0]  = '0;

  hpd_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .accept_i       (accept),
    .coded_sample_i (coded_sample_i),
    .rd_i           (rd[hpd_pkg::MaxChannels]),
    .head_o         (head),
    .last_o         (last),
    .step_o         (step),
    .res_o          (res)
  );

  for (genvar i = 0; i < hpd_pkg::MaxChannels; i++) begin : g_cell
    hpd_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .step_i    (step),
      .last_i    (last[i]),
      .tok_i     (tok[i]),
      .wr_data_i (res.sample),
      .rd_i      (rd[i]),
      .tok_o     (tok[i+1]),
      .rd_o      (rd[i+1])
    );
  end

  hpd_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_res)
  );

  assign pixel_sample_o = out_res.sample;
  assign row_end_o      = out_res.row_end;
  assign image_end_o    = out_res.image_end;

`ifndef SYNTHESIS
  a_tok_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(tok))
    else $error("channel token lost or duplicated");

  a_image_end_on_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!image_end_o || row_end_o))
    else $error("image end without row end");

  a_ready_low_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input held off with empty output register");
`endif

endmodule
